// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the descriptor walker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define UCDW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UCDW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ucdw_pkg.sv
// ----------------------------------------------------------------------------
// ucdw_pkg
// Types and constants of the USB configuration descriptor walker.
// ----------------------------------------------------------------------------
package ucdw_pkg;

    // walk_status codes
    localparam logic [1:0] PHASE_END = 2'd0;
    localparam logic [1:0] PHASE_BAD = 2'd1;
    localparam logic [1:0] PHASE_RUN = 2'd2;

    // descriptor types and minimum lengths
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] MIN_DESC_LEN   = 8'd3;
    localparam logic [7:0] MIN_IF_LEN     = 8'd9;
    localparam logic [7:0] MIN_EP_LEN     = 8'd7;

    // match flag bit positions
    localparam int FLAG_MATCH   = 0;
    localparam int FLAG_ARMED   = 1;
    localparam int FLAG_EPFOUND = 2;

    // configuration register indexes
    localparam logic [7:0] REG_WANT_IF    = 8'd0;
    localparam logic [7:0] REG_WANT_ALT   = 8'd1;
    localparam logic [7:0] REG_WANT_EP    = 8'd2;
    localparam logic [7:0] REG_COUNT_IFNO = 8'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] want_interface_index;
        logic [7:0] want_alternate_index;
        logic [7:0] want_endpoint_index;
        logic [7:0] count_interface_number;
    } cfg_t;

    typedef struct packed {
        logic        interface_found;
        logic [15:0] interface_offset;
        logic        endpoint_found;
        logic [15:0] endpoint_offset;
        logic [15:0] endpoint_total;
        logic [15:0] alternate_count;
        logic [1:0]  walk_status;
    } result_t;

endpackage

// File: rtl/core/ucdw_in_stage.sv
// ----------------------------------------------------------------------------
// ucdw_in_stage
// Input register: captures one byte item, frees when the walker consumes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucdw_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_last_byte,
    input  logic           pop,
    output logic           item_valid,
    output ucdw_pkg::item_t item
);
    import ucdw_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (pop) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{data_byte: s_data_byte, last_byte: s_last_byte};
        end
    end

    // consume only what is held; a held item is not disturbed
    `UCDW_ASSERT_IMPL(a_pop_has_item, aclk, aresetn, pop, valid_reg, "pop with empty input register")
    `UCDW_ASSERT_NEXT(a_held_item_stable, aclk, aresetn, valid_reg && !pop, valid_reg && $stable(item_reg), "held input item changed")

endmodule

// File: rtl/core/ucdw_walk_core.sv
// ----------------------------------------------------------------------------
// ucdw_walk_core
// Walk state and the combinational per-byte update of the descriptor chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucdw_walk_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  ucdw_pkg::item_t   item,
    input  ucdw_pkg::cfg_t    cfg,
    output logic              fire,
    output ucdw_pkg::result_t res
);
    import ucdw_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] tlen;
        logic [15:0] dstart;
        logic [7:0]  dlen;
        logic [7:0]  dtype;
        logic [1:0]  phase;
        logic        seen;
        logic [7:0]  prev_num;
        logic [7:0]  if_ord;
        logic [7:0]  alt_ord;
        logic [2:0]  flags;
        logic [7:0]  ep_ord;
        logic [15:0] f_if;
        logic [15:0] f_ep;
        logic [15:0] ep_cnt;
        logic [15:0] alt_cnt;
    } walk_state_t;

    localparam walk_state_t WALK_CLEAR = '{phase: PHASE_RUN, default: '0};

    walk_state_t st_reg;
    walk_state_t st_next;

    // chain bounds check of a descriptor starting at start
    function automatic logic [1:0] check_desc(logic [1:0] ph, logic [15:0] start,
                                              logic [7:0] len, logic [15:0] tl);
        logic [16:0] stop_pos;
        stop_pos = {1'b0, start} + {9'b0, len};
        if (start >= tl) begin
            return PHASE_END;
        end else if (stop_pos > {1'b0, tl}) begin
            return PHASE_BAD;
        end else if (len < MIN_DESC_LEN) begin
            return PHASE_BAD;
        end
        return ph;
    endfunction

    // matching and counting, applied at byte 2 of a descriptor (byte 3 for the first one)
    function automatic walk_state_t desc_effects(walk_state_t s_in, logic [7:0] num,
                                                 cfg_t c);
        walk_state_t s;
        s = s_in;
        if (s.dtype == TYPE_ENDPOINT) begin
            s.ep_cnt = s.ep_cnt + 16'd1;
            if (s.flags[FLAG_ARMED]) begin
                if (s.ep_ord == c.want_endpoint_index) begin
                    if (s.dlen >= MIN_EP_LEN) begin
                        s.f_ep               = s.dstart;
                        s.flags[FLAG_EPFOUND] = 1'b1;
                    end
                    s.flags[FLAG_ARMED] = 1'b0;
                end else begin
                    s.ep_ord = s.ep_ord + 8'd1;
                end
            end
        end
        if (s.dtype == TYPE_INTERFACE) begin
            s.flags[FLAG_ARMED] = 1'b0;
            if (s.dlen >= MIN_IF_LEN) begin
                if (!s.seen) begin
                    s.seen     = 1'b1;
                    s.prev_num = num;
                end else if (num != s.prev_num) begin
                    s.prev_num = num;
                    s.if_ord   = s.if_ord + 8'd1;
                    s.alt_ord  = '0;
                end else begin
                    s.alt_ord = s.alt_ord + 8'd1;
                end
                if (num == c.count_interface_number) begin
                    s.alt_cnt = s.alt_cnt + 16'd1;
                end
                if (!s.flags[FLAG_MATCH] && s.if_ord == c.want_interface_index &&
                    s.alt_ord == c.want_alternate_index) begin
                    s.flags[FLAG_MATCH] = 1'b1;
                    s.f_if              = s.dstart;
                end
            end
        end
        return s;
    endfunction

    always_comb begin : walk_step
        walk_state_t s;
        logic        go;
        logic [15:0] o;
        logic [15:0] rel;
        logic [16:0] next_end;
        logic [7:0]  b;

        s        = st_reg;
        o        = st_reg.offset;
        b        = item.data_byte;
        go       = (s.phase == PHASE_RUN);
        rel      = '0;
        next_end = '0;

        if (go) begin
            if (o == 16'd2) s.tlen[7:0]  = b;
            if (o == 16'd3) s.tlen[15:8] = b;

            if (o == 16'd0) begin
                s.dstart = '0;
                s.dlen   = b;
                s.dtype  = '0;
            end else if (o == 16'd3) begin
                // first descriptor waits for the total length
                s.phase = check_desc(s.phase, '0, s.dlen, s.tlen);
                if (s.phase == PHASE_RUN) begin
                    s = desc_effects(s, s.tlen[7:0], cfg);
                end
            end
            go = (s.phase == PHASE_RUN);

            next_end = {1'b0, s.dstart} + {9'b0, s.dlen};
            if (go && o >= 16'd3 && {1'b0, o} == next_end) begin
                s.dstart = o;
                s.dlen   = b;
                s.dtype  = '0;
                s.phase  = check_desc(s.phase, o, b, s.tlen);
                go       = (s.phase == PHASE_RUN);
            end

            if (go) begin
                rel = o - s.dstart;
                if (rel == 16'd1) s.dtype = b;
                if (s.dstart != '0 && rel == 16'd2) begin
                    s = desc_effects(s, b, cfg);
                end
                // bNumEndpoints of the matched interface arms the search
                if (rel == 16'd4 && s.flags[FLAG_MATCH] && s.f_if == s.dstart &&
                    cfg.want_endpoint_index < b) begin
                    s.flags[FLAG_ARMED] = 1'b1;
                    s.ep_ord            = '0;
                end
                if (o >= 16'd3) begin
                    next_end = {1'b0, s.dstart} + {9'b0, s.dlen};
                    if (next_end == ({1'b0, o} + 17'd1) && next_end >= {1'b0, s.tlen}) begin
                        s.phase = PHASE_END;
                    end
                end
            end
        end

        if (s.offset != 16'hFFFF) begin
            s.offset = s.offset + 16'd1;
        end

        res.interface_found  = s.flags[FLAG_MATCH];
        res.interface_offset = s.f_if;
        res.endpoint_found   = s.flags[FLAG_EPFOUND];
        res.endpoint_offset  = s.f_ep;
        res.endpoint_total   = s.ep_cnt;
        res.alternate_count  = s.alt_cnt;
        res.walk_status      = s.phase;

        st_next = item.last_byte ? WALK_CLEAR : s;
    end

    assign fire = step && item.last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= WALK_CLEAR;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

    // the search is armed and a find is made only under a matched interface
    `UCDW_ASSERT_IMPL(a_armed_needs_match, aclk, aresetn, st_reg.flags[FLAG_ARMED], st_reg.flags[FLAG_MATCH], "endpoint search armed without interface match")
    `UCDW_ASSERT_IMPL(a_epfound_needs_match, aclk, aresetn, st_reg.flags[FLAG_EPFOUND], st_reg.flags[FLAG_MATCH], "endpoint found without interface match")
    `UCDW_ASSERT_NEXT(a_walk_restarts, aclk, aresetn, fire, st_reg.offset == 16'd0 && st_reg.phase == PHASE_RUN, "walk not restarted after result")

endmodule

// File: rtl/core/usb_config_descriptor_walker.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_walker
// Streams a USB configuration descriptor and reports the matched interface,
// endpoint, endpoint total and alternate count.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_*): one descriptor byte per item, offset zero first.
//    s_last_byte marks the final byte; that item produces one result item.
//  - Result channel (m_*): one item per last byte, held until m_ready.
//  - Config port (cfg_*): write while idle; index 0..3 selects
//    want_interface_index, want_alternate_index, want_endpoint_index,
//    count_interface_number. Other indexes are ignored.
//  - Throughput: one byte per cycle while no last byte waits; the walk state
//    is updated combinationally from the input register, so bytes follow back to back.
//  - Result path: a last byte goes through the input register, then the
//    result register, whose output is m_valid.
//  - Stall: while a result waits, non-last bytes keep flowing; a last byte
//    waits in the input register until the result register frees.
//  - Reset: configuration registers read zero, walk restarts at offset zero, no result
//    pending. After each result the walk restarts for a new descriptor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usb_config_descriptor_walker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [7:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_interface_found,
    output logic [15:0] m_interface_offset,
    output logic        m_endpoint_found,
    output logic [15:0] m_endpoint_offset,
    output logic [15:0] m_endpoint_total,
    output logic [15:0] m_alternate_count,
    output logic [1:0]  m_walk_status
);
    import ucdw_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid;
    item_t   in_item;
    logic    out_free;
    logic    core_step;
    logic    core_fire;
    result_t core_res;
    logic    m_valid_reg;
    result_t res_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WANT_IF:    cfg_reg.want_interface_index   <= cfg_wdata;
                REG_WANT_ALT:   cfg_reg.want_alternate_index   <= cfg_wdata;
                REG_WANT_EP:    cfg_reg.want_endpoint_index    <= cfg_wdata;
                REG_COUNT_IFNO: cfg_reg.count_interface_number <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ucdw_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .pop         (core_step),
        .item_valid  (in_valid),
        .item        (in_item)
    );

    // only a last byte needs room in the result register
    assign out_free  = !m_valid_reg || m_ready;
    assign core_step = in_valid && (!in_item.last_byte || out_free);

    ucdw_walk_core u_walk_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (core_step),
        .item    (in_item),
        .cfg     (cfg_reg),
        .fire    (core_fire),
        .res     (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire) begin
            res_reg <= core_res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_interface_found  = res_reg.interface_found;
    assign m_interface_offset = res_reg.interface_offset;
    assign m_endpoint_found   = res_reg.endpoint_found;
    assign m_endpoint_offset  = res_reg.endpoint_offset;
    assign m_endpoint_total   = res_reg.endpoint_total;
    assign m_alternate_count  = res_reg.alternate_count;
    assign m_walk_status      = res_reg.walk_status;

    // a new result never overwrites one still waiting
    `UCDW_ASSERT_IMPL(a_no_result_overwrite, aclk, aresetn, core_fire, !m_valid_reg || m_ready, "result register overwritten")

endmodule

// File: tb/tb_usb_config_descriptor_walker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_config_descriptor_walker
// Streams configuration descriptors, well-formed and damaged, through the
// walker under random idling on both sides, predicts each result from an
// in-bench walk of the same bytes and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_usb_config_descriptor_walker;

    import ucdw_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (every input known from time zero)
    // ------------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [7:0]  cfg_addr    = 8'd0;
    logic [7:0]  cfg_wdata   = 8'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_interface_found;
    logic [15:0] m_interface_offset;
    logic        m_endpoint_found;
    logic [15:0] m_endpoint_offset;
    logic [15:0] m_endpoint_total;
    logic [15:0] m_alternate_count;
    logic [1:0]  m_walk_status;

    always #10 aclk = ~aclk;

    usb_config_descriptor_walker dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_interface_found  (m_interface_found),
        .m_interface_offset (m_interface_offset),
        .m_endpoint_found   (m_endpoint_found),
        .m_endpoint_offset  (m_endpoint_offset),
        .m_endpoint_total   (m_endpoint_total),
        .m_alternate_count  (m_alternate_count),
        .m_walk_status      (m_walk_status)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    item_t       byte_queue[$];        // items waiting for the byte driver
    result_t     expected_reports[$];  // predicted results, oldest first
    logic [7:0]  frame_bytes[$];       // descriptor set under construction
    int          desc_starts[$];       // offsets of its descriptors
    int          bytes_queued   = 0;
    int          mismatch_count = 0;
    int          hold_requests  = 0;   // bumped to ask for one long m_ready stall
    logic        quiet_run      = 1'b0; // no idling on either side

    // Register copies used by the prediction
    logic [7:0]  want_if, want_alt, want_ep, count_ifno;

    // Walk state of the prediction
    logic [15:0] walk_pos, len_total, desc_start;
    logic [7:0]  desc_len, desc_type;
    logic [1:0]  scan_phase;
    logic        seen_if;
    logic [7:0]  prev_ifno, if_ord, alt_ord;
    logic [2:0]  hit_flags;            // indexed by FLAG_MATCH/ARMED/EPFOUND
    logic [7:0]  ep_limit, ep_ord;
    logic [15:0] hit_if_off, hit_ep_off, ep_count, alt_count;

    // ------------------------------------------------------------------------
    // Walk prediction
    // ------------------------------------------------------------------------
    function void restart_walk();
        walk_pos   = 16'd0;  len_total = 16'd0;  desc_start = 16'd0;
        desc_len   = 8'd0;   desc_type = 8'd0;   scan_phase = PHASE_RUN;
        seen_if    = 1'b0;   prev_ifno = 8'd0;
        if_ord     = 8'd0;   alt_ord   = 8'd0;   hit_flags  = 3'd0;
        ep_limit   = 8'd0;   ep_ord    = 8'd0;
        hit_if_off = 16'd0;  hit_ep_off = 16'd0;
        ep_count   = 16'd0;  alt_count = 16'd0;
    endfunction

    // A descriptor must start inside the total, end inside it and hold
    // at least length and type plus one byte.
    function void check_bounds(input int unsigned start, input int unsigned len);
        if (start >= len_total)
            scan_phase = PHASE_END;
        else if (start + len > len_total)
            scan_phase = PHASE_BAD;
        else if (len < MIN_DESC_LEN)
            scan_phase = PHASE_BAD;
    endfunction

    // Applied at byte 2 of a descriptor (byte 3 for the first one).
    function void take_descriptor(input logic [7:0] number);
        if (desc_type == TYPE_ENDPOINT) begin
            ep_count = ep_count + 16'd1;
            if (hit_flags[FLAG_ARMED]) begin
                if (ep_ord == want_ep) begin
                    // wanted slot reached: a short endpoint ends the search
                    if (desc_len >= MIN_EP_LEN) begin
                        hit_ep_off = desc_start;
                        hit_flags[FLAG_EPFOUND] = 1'b1;
                    end
                    hit_flags[FLAG_ARMED] = 1'b0;
                end else begin
                    ep_ord = ep_ord + 8'd1;
                end
            end
        end
        if (desc_type == TYPE_INTERFACE) begin
            // any interface-type descriptor ends the endpoint search
            hit_flags[FLAG_ARMED] = 1'b0;
            if (desc_len >= MIN_IF_LEN) begin
                if (!seen_if) begin
                    seen_if   = 1'b1;
                    prev_ifno = number;
                end else if (number != prev_ifno) begin
                    prev_ifno = number;
                    if_ord    = if_ord + 8'd1;
                    alt_ord   = 8'd0;
                end else begin
                    alt_ord = alt_ord + 8'd1;
                end
                if (number == count_ifno)
                    alt_count = alt_count + 16'd1;
                if (!hit_flags[FLAG_MATCH] && if_ord == want_if && alt_ord == want_alt) begin
                    hit_flags[FLAG_MATCH] = 1'b1;
                    hit_if_off = desc_start;
                end
            end
        end
    endfunction

    function void walk_step(input logic [7:0] b);
        int unsigned pos, rel, desc_end;
        pos = walk_pos;
        if (pos == 2) len_total[7:0]  = b;
        if (pos == 3) len_total[15:8] = b;

        if (pos == 0) begin
            desc_start = 16'd0;
            desc_len   = b;
            desc_type  = 8'd0;
        end else if (pos == 3) begin
            // first descriptor is judged once the total is known; its
            // "interface number" is the low total byte
            check_bounds(0, desc_len);
            if (scan_phase == PHASE_RUN)
                take_descriptor(len_total[7:0]);
        end
        if (scan_phase != PHASE_RUN) return;

        desc_end = desc_start + desc_len;
        if (pos >= 3 && pos == desc_end) begin
            desc_start = pos[15:0];
            desc_len   = b;
            desc_type  = 8'd0;
            check_bounds(pos, b);
            if (scan_phase != PHASE_RUN) return;
        end

        rel = pos - desc_start;
        if (rel == 1) desc_type = b;
        if (desc_start != 16'd0 && rel == 2) take_descriptor(b);
        // bNumEndpoints of the matched interface arms the search
        if (rel == 4 && hit_flags[FLAG_MATCH] && hit_if_off == desc_start) begin
            ep_limit = b;
            if (want_ep < b) begin
                hit_flags[FLAG_ARMED] = 1'b1;
                ep_ord = 8'd0;
            end
        end
        if (pos >= 3) begin
            desc_end = desc_start + desc_len;
            if (desc_end == pos + 1 && desc_end >= len_total)
                scan_phase = PHASE_END;
        end
    endfunction

    function void predict_walk_byte(input logic [7:0] b, input logic last);
        result_t r;
        if (scan_phase == PHASE_RUN) walk_step(b);
        if (walk_pos != 16'hFFFF) walk_pos = walk_pos + 16'd1;
        if (last) begin
            r.interface_found  = hit_flags[FLAG_MATCH];
            r.interface_offset = hit_if_off;
            r.endpoint_found   = hit_flags[FLAG_EPFOUND];
            r.endpoint_offset  = hit_ep_off;
            r.endpoint_total   = ep_count;
            r.alternate_count  = alt_count;
            r.walk_status      = scan_phase;
            expected_reports.push_back(r);
            restart_walk();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Idling: each side picks a mode whenever its tick counter wraps (none, heavy, light)
    // ------------------------------------------------------------------------
    function automatic logic idle_now(input logic [1:0] mode);
        case (mode)
            2'd1:    return $urandom_range(0, 3) == 0;
            2'd2:    return $urandom_range(0, 15) == 0;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver: feeds byte_queue onto the input channel
    // ------------------------------------------------------------------------
    int         send_gap  = 0;
    logic [7:0] send_tick = 8'd0;
    logic [1:0] send_mode = 2'd0;

    always @(posedge aclk) begin : byte_driver
        item_t next_item;
        send_tick <= send_tick + 8'd1;
        if (send_tick == 8'd0) send_mode <= 2'($urandom_range(0, 2));
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            // channel free: the previous item (if any) went in at this edge
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (byte_queue.size() != 0 && !quiet_run && idle_now(send_mode)) begin
                s_valid  <= 1'b0;                 // start an idle burst of random length
                send_gap <= $urandom_range(0, 14);
            end else if (byte_queue.size() != 0) begin
                next_item   = byte_queue.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= next_item.data_byte;
                s_last_byte <= next_item.last_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random m_ready bursts plus requested long stalls
    // ------------------------------------------------------------------------
    int         ready_gap   = 0;
    int         hold_left   = 0;
    int         holds_done  = 0;
    logic [7:0] ready_tick  = 8'd0;
    logic [1:0] ready_mode  = 2'd0;

    always @(posedge aclk) begin : ready_driver
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick == 8'd0) ready_mode <= 2'($urandom_range(0, 2));
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            // long stall so the walker fills up and backs off its input
            m_ready    <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= 400;
        end else if (ready_gap != 0) begin
            m_ready   <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (!quiet_run && idle_now(ready_mode)) begin
            m_ready   <= 1'b0;
            ready_gap <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction on every accepted byte, check on every accepted result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : byte_tracker
        if (aresetn && s_valid && s_ready)
            predict_walk_byte(s_data_byte, s_last_byte);
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        // cap the log; the count keeps going
        if (mismatch_count <= 200)
            $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : result_checker
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with nothing outstanding", 16'd0, 16'd0);
            end else begin
                want = expected_reports.pop_front();
                if (m_interface_found !== want.interface_found)
                    report_mismatch("interface_found", 16'(m_interface_found),
                                    16'(want.interface_found));
                if (m_interface_offset !== want.interface_offset)
                    report_mismatch("interface_offset", m_interface_offset,
                                    want.interface_offset);
                if (m_endpoint_found !== want.endpoint_found)
                    report_mismatch("endpoint_found", 16'(m_endpoint_found),
                                    16'(want.endpoint_found));
                if (m_endpoint_offset !== want.endpoint_offset)
                    report_mismatch("endpoint_offset", m_endpoint_offset, want.endpoint_offset);
                if (m_endpoint_total !== want.endpoint_total)
                    report_mismatch("endpoint_total", m_endpoint_total, want.endpoint_total);
                if (m_alternate_count !== want.alternate_count)
                    report_mismatch("alternate_count", m_alternate_count, want.alternate_count);
                if (m_walk_status !== want.walk_status)
                    report_mismatch("walk_status", 16'(m_walk_status), 16'(want.walk_status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Descriptor set construction
    // ------------------------------------------------------------------------
    task automatic add_desc(input int len, input logic [7:0] kind);
        desc_starts.push_back(frame_bytes.size());
        frame_bytes.push_back(8'(len));
        frame_bytes.push_back(kind);
        for (int i = 2; i < len; i++) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic add_interface(input logic [7:0] ifno, input logic [7:0] alt,
                                 input logic [7:0] num_eps);
        desc_starts.push_back(frame_bytes.size());
        frame_bytes.push_back(8'd9);
        frame_bytes.push_back(TYPE_INTERFACE);
        frame_bytes.push_back(ifno);
        frame_bytes.push_back(alt);
        frame_bytes.push_back(num_eps);
        repeat (4) frame_bytes.push_back(8'($urandom));
    endtask

    // configuration header: 9 bytes, type 2, total patched later
    task automatic start_frame();
        frame_bytes.delete();
        desc_starts.delete();
        add_desc(9, 8'd2);
    endtask

    task automatic set_total(input logic [15:0] total);
        frame_bytes[2] = total[7:0];
        frame_bytes[3] = total[15:8];
    endtask

    task automatic trim_frame(input int keep);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endtask

    // queue the set with the last flag on its final byte
    task automatic push_frame();
        item_t it;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            it.data_byte = frame_bytes[i];
            it.last_byte = (i == frame_bytes.size() - 1);
            byte_queue.push_back(it);
        end
        bytes_queued  += frame_bytes.size();
        frame_bytes.delete();
        desc_starts.delete();
    endtask

    // Mostly well-formed sets of a few interfaces with endpoints, with
    // alternates and class-specific descriptors mixed in; about half get
    // one kind of damage.
    task automatic build_random_frame();
        int         groups, eps, ifno;
        logic [7:0] alt;
        start_frame();
        groups = $urandom_range(0, 4);
        ifno   = $urandom_range(0, 3);
        alt    = 8'd0;
        for (int g = 0; g < groups; g++) begin
            if (g != 0 && $urandom_range(0, 2) == 0) begin
                alt = alt + 8'd1;
            end else begin
                ifno = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
                alt  = 8'd0;
            end
            eps = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) add_desc($urandom_range(3, 8), TYPE_INTERFACE);
            add_interface(8'(ifno), alt, 8'(eps));
            if ($urandom_range(0, 3) == 0) add_desc($urandom_range(3, 9), 8'h24);
            eps = $urandom_range(0, eps + 1);
            for (int e = 0; e < eps; e++)
                add_desc(($urandom_range(0, 5) == 0) ? $urandom_range(3, 9) : 7,
                         TYPE_ENDPOINT);
        end
        set_total(16'(frame_bytes.size()));
        case ($urandom_range(0, 9))
            0: trim_frame($urandom_range(1, frame_bytes.size()));          // input short
            1: repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
            2: set_total($urandom_range(0, 1) ? 16'($urandom)
                                              : 16'($urandom_range(0, frame_bytes.size() + 10)));
            3: frame_bytes[desc_starts[$urandom_range(0, desc_starts.size() - 1)]] =
                   8'($urandom);                                          // bad length
            4: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 3));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Register writes (only while idle) and idle wait
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WANT_IF:    want_if    = value;
            REG_WANT_ALT:   want_alt   = value;
            REG_WANT_EP:    want_ep    = value;
            REG_COUNT_IFNO: count_ifno = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] wif, input logic [7:0] walt,
                             input logic [7:0] wep, input logic [7:0] cnt);
        write_reg(REG_WANT_IF, wif);
        write_reg(REG_WANT_ALT, walt);
        write_reg(REG_WANT_EP, wep);
        write_reg(REG_COUNT_IFNO, cnt);
        @(negedge aclk);
    endtask

    // Everything sent and every result back, then a settling wait.
    task automatic wait_idle();
        do @(negedge aclk);
        while (byte_queue.size() != 0 || s_valid || expected_reports.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_no;
        want_if = 8'd0;  want_alt = 8'd0;  want_ep = 8'd0;  count_ifno = 8'd0;
        restart_walk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed sets, registers at reset (all zero) ----
        // header only, total 9: clean end, nothing found
        start_frame(); set_total(16'd9); push_frame();
        // interface 0 alt 0 with two endpoints: both counted, the first found
        start_frame(); add_interface(8'd0, 8'd0, 8'd2);
        add_desc(7, TYPE_ENDPOINT); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size())); push_frame();
        // total length zero: ends at byte 3
        start_frame(); set_total(16'd0); push_frame();
        // first descriptor too short
        start_frame(); frame_bytes[0] = 8'd2; set_total(16'd9); push_frame();
        // first descriptor is itself an interface; its number is the total's low byte
        start_frame(); frame_bytes[1] = TYPE_INTERFACE; frame_bytes[4] = 8'd1;
        add_desc(7, TYPE_ENDPOINT); set_total(16'd16); push_frame();
        // descriptor overrunning the total
        start_frame(); add_desc(15, 8'h24); set_total(16'd20); push_frame();
        // input ends inside a descriptor
        start_frame(); add_interface(8'd0, 8'd0, 8'd1); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size())); trim_frame(14); push_frame();
        // bytes after the end are ignored
        start_frame(); add_interface(8'd0, 8'd0, 8'd1); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size()));
        repeat (5) frame_bytes.push_back(8'($urandom));
        push_frame();
        // wanted endpoint shorter than 7 bytes ends the search without a find
        start_frame(); add_interface(8'd0, 8'd0, 8'd1);
        add_desc(6, TYPE_ENDPOINT); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size())); push_frame();
        // an alternate interface cuts the search short
        start_frame(); add_interface(8'd0, 8'd0, 8'd2); add_desc(5, 8'h24);
        add_interface(8'd0, 8'd1, 8'd1); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size())); push_frame();
        // bNumEndpoints zero: search never armed
        start_frame(); add_interface(8'd0, 8'd0, 8'd0); add_desc(7, TYPE_ENDPOINT);
        set_total(16'(frame_bytes.size())); push_frame();
        // short interface is not numbered
        start_frame(); add_desc(8, TYPE_INTERFACE); add_interface(8'd0, 8'd0, 8'd1);
        add_desc(7, TYPE_ENDPOINT); set_total(16'(frame_bytes.size())); push_frame();
        // zero length in mid chain
        start_frame(); add_desc(5, 8'h24); frame_bytes[desc_starts[$]] = 8'd0;
        set_total(16'(frame_bytes.size())); push_frame();
        // one byte only, and a run of all-ones bytes
        frame_bytes.push_back(8'd0); push_frame();
        repeat (6) frame_bytes.push_back(8'hFF);
        push_frame();

        // ---- random phases, each with its own register setting ----
        phase_no = 0;
        while (bytes_queued < 900 || phase_no < 3) begin
            wait_idle();
            if (phase_no == 0)
                write_all(8'd255, 8'd255, 8'd255, 8'd255);
            else
                write_all(pick_setting(), pick_setting(), pick_setting(), pick_setting());
            if (phase_no == 2) begin
                // receiver stalls while tiny sets pile up behind it
                hold_requests = hold_requests + 1;
                repeat (40) begin
                    repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
                    push_frame();
                end
            end
            repeat (4) begin
                build_random_frame();
                push_frame();
            end
            phase_no++;
        end

        // ---- closing stretch without idling ----
        wait_idle();
        @(negedge aclk);
        quiet_run = 1'b1;
        write_all(8'd0, 8'd0, 8'd0, 8'd0);
        repeat (4) begin
            build_random_frame();
            push_frame();
        end

        wait_idle();
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout well beyond the slowest legal run
    initial begin : watchdog
        #(100_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ucdw_pkg.sv
rtl/core/ucdw_in_stage.sv
rtl/core/ucdw_walk_core.sv
rtl/core/usb_config_descriptor_walker.sv
tb/tb_usb_config_descriptor_walker.sv
